// File: rtl/lphs_pkg.sv
// ----------------------------------------------------------------------------
// lphs_pkg: shared types and constants
// Request kinds, slot marks, slot entry layout, sequencer states and
// fixed field widths of the linear-probe hash set.
// ----------------------------------------------------------------------------
package lphs_pkg;

  localparam int KEY_W       = 32;
  localparam int KIND_W      = 2;
  localparam int MAX_RESULTS = 64;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int STORED_W    = 7;
  localparam int STORED_MAX  = 127;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_LIST   = 2'd3
  } kind_t;

  // mark code 3 never arises; it decodes like a deleted slot
  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_FILLED  = 2'd1,
    MARK_DELETED = 2'd2
  } mark_t;

  typedef struct packed {
    mark_t            mark;
    logic [KEY_W-1:0] key;
  } slot_t;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_HOME   = 6'b000100,
    ST_PROBE  = 6'b001000,
    ST_LIST   = 6'b010000,
    ST_LEMPTY = 6'b100000
  } state_t;

endpackage

// File: rtl/lphs_home.sv
// ----------------------------------------------------------------------------
// lphs_home: home slot unit
// Computes key modulo TABLE_SLOTS. A power-of-two slot count is a mask;
// otherwise a reciprocal multiply, a back-multiply and one correcting
// subtract, one step per cycle, each registered in turn.
// ----------------------------------------------------------------------------
module lphs_home #(
  parameter int TABLE_SLOTS = 64,
  localparam int IDX_W = $clog2(TABLE_SLOTS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lphs_pkg::KEY_W-1:0] key,
  output logic                       done,
  output logic [IDX_W-1:0]           home
);

  localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

  generate
    if (IS_POW2) begin : g_mask
      logic             done_r;
      logic [IDX_W-1:0] home_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          home_r <= key[IDX_W-1:0];
        end
      end

      assign done = done_r;
      assign home = home_r;
    end else begin : g_recip
      // floor(2^32 / TABLE_SLOTS): the quotient estimate is exact or one low,
      // so the first remainder is below twice the slot count
      localparam logic [lphs_pkg::KEY_W-1:0] RECIP =
        lphs_pkg::KEY_W'((64'd1 << lphs_pkg::KEY_W) / 64'(TABLE_SLOTS));
      localparam logic [lphs_pkg::KEY_W-1:0] SLOTS_K = lphs_pkg::KEY_W'(TABLE_SLOTS);
      localparam logic [IDX_W:0]             SLOTS_V = (IDX_W + 1)'(TABLE_SLOTS);

      logic [2:0]                     phase_r;   // one-hot: quotient, remainder, fold
      logic                           done_r;
      logic [lphs_pkg::KEY_W-1:0]     key_r;
      logic [lphs_pkg::KEY_W-1:0]     quo_r;
      logic [IDX_W:0]                 rem_r;
      logic [IDX_W-1:0]               home_r;
      logic [2*lphs_pkg::KEY_W-1:0]   prod;
      logic [lphs_pkg::KEY_W-1:0]     diff;

      always_comb begin
        prod = {{lphs_pkg::KEY_W{1'b0}}, key_r} * {{lphs_pkg::KEY_W{1'b0}}, RECIP};
        diff = key_r - quo_r * SLOTS_K;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          phase_r <= '0;
          done_r  <= 1'b0;
        end else begin
          phase_r <= {phase_r[1:0], start};
          done_r  <= phase_r[2];
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          key_r <= key;
        end
        if (phase_r[0]) begin
          quo_r <= prod[2*lphs_pkg::KEY_W-1:lphs_pkg::KEY_W];
        end
        if (phase_r[1]) begin
          rem_r <= diff[IDX_W:0];
        end
        if (phase_r[2]) begin
          home_r <= (rem_r >= SLOTS_V) ? IDX_W'(rem_r - SLOTS_V) : rem_r[IDX_W-1:0];
        end
      end

      assign done = done_r;
      assign home = home_r;
    end
  endgenerate

endmodule

// File: rtl/lphs_slot_ram.sv
// ----------------------------------------------------------------------------
// lphs_slot_ram: slot table
// One entry per slot holding mark and key; one write and one registered
// read port.
// ----------------------------------------------------------------------------
module lphs_slot_ram #(
  parameter int TABLE_SLOTS = 64,
  localparam int IDX_W = $clog2(TABLE_SLOTS)
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output lphs_pkg::slot_t     rd_data,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  lphs_pkg::slot_t     wr_data
);

  lphs_pkg::slot_t mem [TABLE_SLOTS];
  lphs_pkg::slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/linear_probe_hash_set.sv
// Add/remove/find: home slot computed, then slots probed in turn from it
//   (1..TABLE_SLOTS slots); result then registered.
// List: slots scanned in order up to the last key listed, one beat per key.
// Throughput: one request at a time, next accepted the cycle after its last beat loads.
// Reset: slot table clearing pass over every slot, in_stall held high meanwhile.
// ----------------------------------------------------------------------------
// linear_probe_hash_set_unit: open-addressing hash set, linear probing
// Sequencer around one slot table read port, a home slot unit and a
// single compare path; tombstones on removal, listing in slot order.
// ----------------------------------------------------------------------------
module linear_probe_hash_set_unit #(
  parameter int TABLE_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lphs_pkg::KIND_W-1:0]   in_kind,
  input  logic [lphs_pkg::KEY_W-1:0]    in_key,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [lphs_pkg::KEY_W-1:0]    out_key_out,
  output logic                          out_table_full,
  output logic [lphs_pkg::STORED_W-1:0] out_stored_count,
  output logic                          out_last
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  // common width for count compares against the result limit and saturation
  localparam int CMP_W = (CNT_W > lphs_pkg::RES_CNT_W) ? CNT_W : lphs_pkg::RES_CNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  lphs_pkg::state_t               state_r, state_nxt;
  lphs_pkg::kind_t                kind_r, kind_nxt;
  logic [lphs_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [IDX_W-1:0]               idx_r, idx_nxt;        // slot under test / clear pointer
  logic [IDX_W-1:0]               step_r, step_nxt;      // slots probed so far
  logic                           reuse_vld_r, reuse_vld_nxt;
  logic [IDX_W-1:0]               reuse_idx_r, reuse_idx_nxt;
  logic [lphs_pkg::RES_CNT_W-1:0] n_r, n_nxt;            // list beats sent
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;        // keys held

  // result register
  logic                           out_valid_r;
  logic                           found_r;
  logic [lphs_pkg::KEY_W-1:0]     key_out_r;
  logic                           table_full_r;
  logic [lphs_pkg::STORED_W-1:0]  stored_r;
  logic                           last_r;

  // result load
  logic                           out_free;
  logic                           out_load;
  logic                           ld_found;
  logic [lphs_pkg::KEY_W-1:0]     ld_key;
  logic                           ld_full;
  logic                           ld_last;

  // slot table ports
  logic                           rd_en;
  logic [IDX_W-1:0]               rd_addr;
  lphs_pkg::slot_t                rd_data;
  logic                           wr_en;
  logic [IDX_W-1:0]               wr_addr;
  lphs_pkg::slot_t                wr_data;

  // home slot unit
  logic                           home_start;
  logic                           home_done;
  logic [IDX_W-1:0]               home;

  // probe decode
  logic                           pr_hit;
  logic                           pr_stop;
  logic                           pr_cand;
  logic                           reuse_has;
  logic [IDX_W-1:0]               reuse_at;
  logic [IDX_W-1:0]               idx_inc;

  // counts
  logic [CMP_W-1:0]               cnt_ext;
  logic [CMP_W-1:0]               list_lim;
  logic [CMP_W-1:0]               n_plus;
  logic [CMP_W-1:0]               cnt_nxt_ext;
  logic [lphs_pkg::STORED_W-1:0]  shown;

  logic                           in_acc;

  // --------------------------------------------------------------------------
  // Submodules
  // --------------------------------------------------------------------------
  lphs_home #(.TABLE_SLOTS(TABLE_SLOTS)) u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .start (home_start),
    .key   (in_key),
    .done  (home_done),
    .home  (home)
  );

  lphs_slot_ram #(.TABLE_SLOTS(TABLE_SLOTS)) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign in_stall   = (state_r != lphs_pkg::ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign home_start = in_acc && (lphs_pkg::kind_t'(in_kind) != lphs_pkg::KIND_LIST);
  // output register can take a new beat if empty or being drained this cycle
  assign out_free   = !out_valid_r || !out_stall;

  // --------------------------------------------------------------------------
  // Probe decode on the slot just read
  // --------------------------------------------------------------------------
  always_comb begin
    pr_hit  = 1'b0;
    pr_stop = 1'b0;
    pr_cand = 1'b0;
    case (rd_data.mark)
      lphs_pkg::MARK_FILLED: begin
        if (rd_data.key == key_r) begin
          pr_hit  = 1'b1;
          pr_stop = 1'b1;
        end
      end
      lphs_pkg::MARK_EMPTY: begin
        pr_cand = 1'b1;
        pr_stop = 1'b1;
      end
      default: begin
        pr_cand = 1'b1;     // tombstone: reusable, keep walking
      end
    endcase
  end

  // first reusable slot, including the one under test
  assign reuse_has = reuse_vld_r || pr_cand;
  assign reuse_at  = reuse_vld_r ? reuse_idx_r : idx_r;
  assign idx_inc   = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;

  // list limit: min(keys held, MAX_RESULTS); filled slots always equal cnt_r
  assign cnt_ext  = CMP_W'(cnt_r);
  assign list_lim = (cnt_ext > CMP_W'(lphs_pkg::MAX_RESULTS)) ?
                    CMP_W'(lphs_pkg::MAX_RESULTS) : cnt_ext;
  assign n_plus   = CMP_W'(n_r) + 1'b1;

  // stored_count saturates for large tables
  assign cnt_nxt_ext = CMP_W'(cnt_nxt);
  assign shown = (cnt_nxt_ext > CMP_W'(lphs_pkg::STORED_MAX)) ?
                 lphs_pkg::STORED_W'(lphs_pkg::STORED_MAX) :
                 cnt_nxt_ext[lphs_pkg::STORED_W-1:0];

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    reuse_vld_nxt = reuse_vld_r;
    reuse_idx_nxt = reuse_idx_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;

    rd_en   = 1'b0;
    rd_addr = idx_r;
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = lphs_pkg::slot_t'{mark: lphs_pkg::MARK_EMPTY, key: '0};

    out_load = 1'b0;
    ld_found = 1'b0;
    ld_key   = '0;
    ld_full  = 1'b0;
    ld_last  = 1'b1;

    case (state_r)
      // sweep every slot to empty after reset
      lphs_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        idx_nxt = idx_inc;
        if (idx_r == LAST_IDX) begin
          state_nxt = lphs_pkg::ST_IDLE;
        end
      end

      lphs_pkg::ST_IDLE: begin
        if (in_acc) begin
          kind_nxt = lphs_pkg::kind_t'(in_kind);
          key_nxt  = in_key;
          if (lphs_pkg::kind_t'(in_kind) == lphs_pkg::KIND_LIST) begin
            if (cnt_r == '0) begin
              state_nxt = lphs_pkg::ST_LEMPTY;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              idx_nxt   = '0;
              n_nxt     = '0;
              state_nxt = lphs_pkg::ST_LIST;
            end
          end else begin
            step_nxt      = '0;
            reuse_vld_nxt = 1'b0;
            state_nxt     = lphs_pkg::ST_HOME;
          end
        end
      end

      lphs_pkg::ST_HOME: begin
        if (home_done) begin
          rd_en     = 1'b1;
          rd_addr   = home;
          idx_nxt   = home;
          state_nxt = lphs_pkg::ST_PROBE;
        end
      end

      // one slot per cycle; read of the next slot issued alongside the check
      lphs_pkg::ST_PROBE: begin
        if (pr_stop || (step_r == LAST_IDX)) begin
          if (out_free) begin
            out_load  = 1'b1;
            ld_found  = pr_hit;
            state_nxt = lphs_pkg::ST_IDLE;
            case (kind_r)
              lphs_pkg::KIND_ADD: begin
                if (!pr_hit) begin
                  if (reuse_has) begin
                    wr_en   = 1'b1;
                    wr_addr = reuse_at;
                    wr_data = lphs_pkg::slot_t'{mark: lphs_pkg::MARK_FILLED, key: key_r};
                    cnt_nxt = cnt_r + 1'b1;
                  end else begin
                    ld_full = 1'b1;
                  end
                end
              end
              lphs_pkg::KIND_REMOVE: begin
                if (pr_hit) begin
                  wr_en   = 1'b1;
                  wr_addr = idx_r;
                  wr_data = lphs_pkg::slot_t'{mark: lphs_pkg::MARK_DELETED,
                                              key: rd_data.key};
                  if (cnt_r != '0) begin
                    cnt_nxt = cnt_r - 1'b1;
                  end
                end
              end
              default: begin
                if (pr_hit) begin
                  ld_key = rd_data.key;
                end
              end
            endcase
          end
        end else begin
          reuse_vld_nxt = reuse_has;
          reuse_idx_nxt = reuse_at;
          idx_nxt       = idx_inc;
          step_nxt      = step_r + 1'b1;
          rd_en         = 1'b1;
          rd_addr       = idx_inc;
        end
      end

      // scan in slot order; a filled slot waits for the output register
      lphs_pkg::ST_LIST: begin
        if (rd_data.mark == lphs_pkg::MARK_FILLED) begin
          if (out_free) begin
            out_load = 1'b1;
            ld_found = 1'b1;
            ld_key   = rd_data.key;
            ld_last  = (n_plus == list_lim);
            n_nxt    = n_r + 1'b1;
            if (n_plus == list_lim) begin
              state_nxt = lphs_pkg::ST_IDLE;
            end else begin
              idx_nxt = idx_inc;
              rd_en   = 1'b1;
              rd_addr = idx_inc;
            end
          end
        end else begin
          idx_nxt = idx_inc;
          rd_en   = 1'b1;
          rd_addr = idx_inc;
        end
      end

      lphs_pkg::ST_LEMPTY: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = lphs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lphs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lphs_pkg::ST_CLEAR;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    key_r       <= key_nxt;
    step_r      <= step_nxt;
    reuse_vld_r <= reuse_vld_nxt;
    reuse_idx_r <= reuse_idx_nxt;
    n_r         <= n_nxt;
    if (out_load) begin
      found_r      <= ld_found;
      key_out_r    <= ld_key;
      table_full_r <= ld_full;
      stored_r     <= shown;
      last_r       <= ld_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = found_r;
  assign out_key_out      = key_out_r;
  assign out_table_full   = table_full_r;
  assign out_stored_count = stored_r;
  assign out_last         = last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a new beat never overwrites one still held by the consumer
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result beat overwritten while stalled");

  // the table is only written by the clearing pass or at the end of a probe
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == lphs_pkg::ST_CLEAR) || (state_r == lphs_pkg::ST_PROBE))
    else $error("slot table written outside clear or probe");

  // key count never exceeds the slot count
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(cnt_r) <= CMP_W'(TABLE_SLOTS))
    else $error("key count above slot count");

  // a listing never sends more beats than its limit
  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lphs_pkg::ST_LIST) |-> (CMP_W'(n_r) < list_lim))
    else $error("listing ran past its last beat");

  // a finished request always leaves a result beat behind
  a_done_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != lphs_pkg::ST_IDLE) && (state_nxt == lphs_pkg::ST_IDLE) &&
    (state_r != lphs_pkg::ST_CLEAR) |=> out_valid_r)
    else $error("request finished without a result beat");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: linear_probe_hash_set_unit
// Drives add, remove, find and list requests into the hash set. A shadow
// table in the bench predicts every result beat, and each beat that leaves
// the unit is checked field by field against the oldest awaited beat. Both
// sides idle and stall at random, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SLOTS          = 64;
  localparam int HOLD_OFF       = 300;   // long receiver hold-off, in cycles
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on either side
  localparam int SETTLE         = 150;   // tail after the last awaited beat

  // one result beat as the unit should present it
  typedef struct packed {
    logic                          found;
    logic [lphs_pkg::KEY_W-1:0]    key;
    logic                          full;
    logic [lphs_pkg::STORED_W-1:0] count;
    logic                          last;
  } beat_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [lphs_pkg::KIND_W-1:0]   in_kind;
  logic [lphs_pkg::KEY_W-1:0]    in_key;
  logic                          out_valid;
  logic                          out_stall;
  logic                          out_found;
  logic [lphs_pkg::KEY_W-1:0]    out_key_out;
  logic                          out_table_full;
  logic [lphs_pkg::STORED_W-1:0] out_stored_count;
  logic                          out_last;

  linear_probe_hash_set_unit #(
    .TABLE_SLOTS(SLOTS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_key_out     (out_key_out),
    .out_table_full  (out_table_full),
    .out_stored_count(out_stored_count),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow hash set: slot marks, slot keys and key total, kept in step with
  // the unit at each accepted request beat.
  // --------------------------------------------------------------------------
  lphs_pkg::mark_t            shadow_mark [SLOTS];
  logic [lphs_pkg::KEY_W-1:0] shadow_key  [SLOTS];
  int unsigned                held;
  beat_t                      replies_due [$];   // beats still owed, oldest first

  int  errors;
  bit  idle_on;        // random idling on both sides
  int  hold_request;   // receiver picks this up and holds off that many cycles

  function automatic logic [lphs_pkg::STORED_W-1:0] shown_total();
    return (held > lphs_pkg::STORED_MAX) ?
           lphs_pkg::STORED_W'(lphs_pkg::STORED_MAX) : lphs_pkg::STORED_W'(held);
  endfunction

  // Linear probe from the home slot, at most SLOTS slots. Hit: where is the
  // matching slot. Miss: where is the first deleted or empty slot met, or
  // SLOTS if the probe met neither.
  function automatic bit probe_shadow(input logic [lphs_pkg::KEY_W-1:0] key,
                                      output int where);
    int home;
    int idx;
    home  = int'(key % SLOTS);
    where = SLOTS;
    for (int p = 0; p < SLOTS; p++) begin
      idx = (home + p) % SLOTS;
      if (shadow_mark[idx] == lphs_pkg::MARK_FILLED) begin
        if (shadow_key[idx] == key) begin
          where = idx;
          return 1'b1;
        end
      end else begin
        // deleted (and the unused code 3) is reusable but does not stop the walk
        if (where == SLOTS) where = idx;
        if (shadow_mark[idx] == lphs_pkg::MARK_EMPTY) break;
      end
    end
    return 1'b0;
  endfunction

  // Apply one request to the shadow set and queue the beats it must produce.
  function automatic void apply_request(input lphs_pkg::kind_t kind,
                                        input logic [lphs_pkg::KEY_W-1:0] key);
    beat_t r;
    bit    have;
    bit    hit;
    int    where;
    int    n;
    r = '0;
    if (kind == lphs_pkg::KIND_LIST) begin
      // hold each entry back one step so the final one can carry last
      have = 1'b0;
      n    = 0;
      for (int i = 0; i < SLOTS && n < lphs_pkg::MAX_RESULTS; i++) begin
        if (shadow_mark[i] == lphs_pkg::MARK_FILLED) begin
          if (have) replies_due.push_back(r);
          r       = '0;
          r.found = 1'b1;
          r.key   = shadow_key[i];
          r.count = shown_total();
          have    = 1'b1;
          n++;
        end
      end
      if (!have) r.count = shown_total();  // empty listing: one bare beat
      r.last = 1'b1;
      replies_due.push_back(r);
      return;
    end
    hit = probe_shadow(key, where);
    r.found = hit;
    r.last  = 1'b1;
    case (kind)
      lphs_pkg::KIND_ADD: begin
        if (!hit) begin
          if (where < SLOTS) begin
            shadow_key[where]  = key;
            shadow_mark[where] = lphs_pkg::MARK_FILLED;
            held++;
          end else begin
            r.full = 1'b1;  // no empty or deleted slot: dropped
          end
        end
      end
      lphs_pkg::KIND_REMOVE: begin
        if (hit) begin
          shadow_mark[where] = lphs_pkg::MARK_DELETED;  // tombstone
          if (held > 0) held--;
        end
      end
      default: begin
        if (hit) r.key = shadow_key[where];
      end
    endcase
    r.count = shown_total();
    replies_due.push_back(r);
  endfunction

  function automatic logic [lphs_pkg::KEY_W-1:0] pick_stored_key();
    int idx;
    do idx = $urandom_range(SLOTS - 1);
    while (shadow_mark[idx] != lphs_pkg::MARK_FILLED);
    return shadow_key[idx];
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Called at a rising edge; returns at the edge where the beat
  // was taken, with valid still high so back-to-back beats need no gap.
  // --------------------------------------------------------------------------
  task automatic send_request(input lphs_pkg::kind_t kind,
                              input logic [lphs_pkg::KEY_W-1:0] key);
    if (idle_on && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_key   <= key;
    do @(posedge clk); while (in_stall !== 1'b0);
    apply_request(kind, key);
  endtask

  // drop valid and wait until every awaited beat has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked keys: misses on an empty set, collisions on home slot 0 and
  // home slot 63 (the latter wraps), duplicate add, tombstone walk-through
  // and reuse, key extremes, listings empty and full of tombstones.
  task automatic test_directed();
    send_request(lphs_pkg::KIND_LIST,   32'h0000_0000);  // empty listing
    send_request(lphs_pkg::KIND_FIND,   32'h0000_0005);
    send_request(lphs_pkg::KIND_REMOVE, 32'h0000_0005);
    send_request(lphs_pkg::KIND_ADD,    32'h0000_0000);
    send_request(lphs_pkg::KIND_ADD,    32'hFFFF_FFFF);  // home 63
    send_request(lphs_pkg::KIND_ADD,    32'h0000_0040);  // home 0, lands in slot 1
    send_request(lphs_pkg::KIND_ADD,    32'hFFFF_FFBF);  // home 63, wraps past 0 and 1
    send_request(lphs_pkg::KIND_ADD,    32'h0000_0000);  // already present
    send_request(lphs_pkg::KIND_FIND,   32'h0000_0040);
    send_request(lphs_pkg::KIND_FIND,   32'hFFFF_FFBF);
    send_request(lphs_pkg::KIND_REMOVE, 32'h0000_0000);  // tombstone in slot 0
    send_request(lphs_pkg::KIND_FIND,   32'h0000_0040);  // walks past the tombstone
    send_request(lphs_pkg::KIND_FIND,   32'hFFFF_FFBF);
    send_request(lphs_pkg::KIND_ADD,    32'h0000_0080);  // reuses the tombstone
    send_request(lphs_pkg::KIND_ADD,    32'hAAAA_AAAA);
    send_request(lphs_pkg::KIND_ADD,    32'h5555_5555);
    send_request(lphs_pkg::KIND_FIND,   32'h5555_5555);
    send_request(lphs_pkg::KIND_LIST,   32'hFFFF_FFFF);
    send_request(lphs_pkg::KIND_REMOVE, 32'hFFFF_FFFF);
    send_request(lphs_pkg::KIND_FIND,   32'hFFFF_FFFF);
    send_request(lphs_pkg::KIND_REMOVE, 32'h0000_0040);
    send_request(lphs_pkg::KIND_REMOVE, 32'h0000_0080);
    send_request(lphs_pkg::KIND_REMOVE, 32'hFFFF_FFBF);
    send_request(lphs_pkg::KIND_REMOVE, 32'hAAAA_AAAA);
    send_request(lphs_pkg::KIND_REMOVE, 32'h5555_5555);
    send_request(lphs_pkg::KIND_LIST,   32'h0000_0000);  // only tombstones left
  endtask

  // Fill every slot, hit the full-table cases, then empty it into a table
  // of tombstones with no empty slot, where every miss walks all slots.
  task automatic test_full_table();
    logic [lphs_pkg::KEY_W-1:0] k;
    int                         where;
    while (held < SLOTS) begin
      k = $urandom();
      if ($urandom_range(1)) k = k - k % SLOTS + $urandom_range(3);  // crowd homes
      send_request(lphs_pkg::KIND_ADD, k);
    end
    do k = $urandom(); while (probe_shadow(k, where));
    send_request(lphs_pkg::KIND_ADD,    k);                  // dropped, table full
    send_request(lphs_pkg::KIND_FIND,   k);                  // full-length miss
    send_request(lphs_pkg::KIND_REMOVE, k);
    send_request(lphs_pkg::KIND_ADD,    pick_stored_key());  // present, full table
    send_request(lphs_pkg::KIND_FIND,   pick_stored_key());
    send_request(lphs_pkg::KIND_LIST,   k);                  // every slot listed
    repeat (8) send_request(lphs_pkg::KIND_REMOVE, pick_stored_key());
    send_request(lphs_pkg::KIND_ADD,    k);                  // lands on a tombstone
    send_request(lphs_pkg::KIND_FIND,   k);
    while (held > 0) send_request(lphs_pkg::KIND_REMOVE, pick_stored_key());
    send_request(lphs_pkg::KIND_FIND,   k);                  // no empty slot anywhere
    send_request(lphs_pkg::KIND_ADD,    k);
    send_request(lphs_pkg::KIND_LIST,   k);
  endtask

  // Mixed traffic: half the keys are stored ones, many share a few home
  // slots to build long chains, the rest are fully random.
  task automatic test_random(input int count);
    lphs_pkg::kind_t            kind;
    logic [lphs_pkg::KEY_W-1:0] key;
    int                         roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 10)      kind = lphs_pkg::KIND_LIST;
      else if (roll < 45) kind = (held > 48) ? lphs_pkg::KIND_REMOVE : lphs_pkg::KIND_ADD;
      else if (roll < 72) kind = lphs_pkg::KIND_REMOVE;
      else                kind = lphs_pkg::KIND_FIND;
      roll = $urandom_range(99);
      key  = $urandom();
      if (roll < 50 && held > 0) key = pick_stored_key();
      else if (roll < 80)        key = key - key % SLOTS + $urandom_range(3);
      send_request(kind, key);
    end
  endtask

  // Receiver holds off while requests keep coming, so the unit backs up and
  // stalls its input; the sender then pauses until everything has drained.
  task automatic test_backpressure();
    hold_request = HOLD_OFF;
    test_random(24);
    wait_drained();
  endtask

  // A long stretch with no idling on either side.
  task automatic test_no_idle();
    idle_on = 1'b0;
    test_random(120);
    idle_on = 1'b1;
  endtask

  initial begin
    foreach (shadow_mark[i]) shadow_mark[i] = lphs_pkg::MARK_EMPTY;
    held         = 0;
    errors       = 0;
    idle_on      = 1'b1;
    hold_request = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_kind  <= lphs_pkg::KIND_ADD;
    in_key   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // the unit clears its slot table after reset; in_stall covers that
    test_directed();
    test_full_table();
    test_random(80);
    test_backpressure();
    test_no_idle();
    test_random(80);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("PASS linear_probe_hash_set_unit");
    end else begin
      $display("FAIL linear_probe_hash_set_unit");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stall, or a counted hold-off when one is requested.
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 25);
      end
    end
  end

  // check each accepted result beat against the oldest awaited one
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (replies_due.size() == 0) begin
        $error("result beat with nothing awaited");
        errors++;
      end else begin
        want = replies_due.pop_front();
        if (out_found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_found);
          errors++;
        end
        if (out_key_out !== want.key) begin
          $error("key_out: expected %08h, got %08h", want.key, out_key_out);
          errors++;
        end
        if (out_table_full !== want.full) begin
          $error("table_full: expected %0d, got %0d", want.full, out_table_full);
          errors++;
        end
        if (out_stored_count !== want.count) begin
          $error("stored_count: expected %0d, got %0d", want.count, out_stored_count);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          errors++;
        end
      end
    end
  end

  // watchdog: too long without a beat on either channel ends the run
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL linear_probe_hash_set_unit");
      $finish;
    end
  end

endmodule
